>>> rtl/stlex_pkg.sv
// Shared types and constants for the script token lexer.
package stlex_pkg;

  localparam int LINE_W  = 16;
  localparam int COL_W   = 12;
  localparam int LEN_W   = 12;
  localparam int KIND_W  = 6;
  localparam int ERR_W   = 3;
  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic SORT_TOKEN = 1'b0;
  localparam logic SORT_BYTE  = 1'b1;

  localparam logic [KIND_W-1:0] K_IDENT    = 6'd0;
  localparam logic [KIND_W-1:0] K_NUMBER   = 6'd22;
  localparam logic [KIND_W-1:0] K_STRING   = 6'd23;
  localparam logic [KIND_W-1:0] K_LPAREN   = 6'd24;
  localparam logic [KIND_W-1:0] K_RPAREN   = 6'd25;
  localparam logic [KIND_W-1:0] K_LBRACE   = 6'd26;
  localparam logic [KIND_W-1:0] K_RBRACE   = 6'd27;
  localparam logic [KIND_W-1:0] K_LBRACKET = 6'd28;
  localparam logic [KIND_W-1:0] K_RBRACKET = 6'd29;
  localparam logic [KIND_W-1:0] K_COMMA    = 6'd30;
  localparam logic [KIND_W-1:0] K_SEMI     = 6'd31;
  localparam logic [KIND_W-1:0] K_PERCENT  = 6'd32;
  localparam logic [KIND_W-1:0] K_CARET    = 6'd33;
  localparam logic [KIND_W-1:0] K_HASH     = 6'd34;
  localparam logic [KIND_W-1:0] K_PLUS     = 6'd35;
  localparam logic [KIND_W-1:0] K_STAR     = 6'd36;
  localparam logic [KIND_W-1:0] K_MINUS    = 6'd37;
  localparam logic [KIND_W-1:0] K_SLASH    = 6'd38;
  localparam logic [KIND_W-1:0] K_DOT      = 6'd39;
  localparam logic [KIND_W-1:0] K_CONCAT   = 6'd40;
  localparam logic [KIND_W-1:0] K_ELLIPSIS = 6'd41;
  localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd42;
  localparam logic [KIND_W-1:0] K_EQ       = 6'd43;
  localparam logic [KIND_W-1:0] K_NE       = 6'd44;
  localparam logic [KIND_W-1:0] K_LT       = 6'd45;
  localparam logic [KIND_W-1:0] K_LE       = 6'd46;
  localparam logic [KIND_W-1:0] K_GT       = 6'd47;
  localparam logic [KIND_W-1:0] K_GE       = 6'd48;
  localparam logic [KIND_W-1:0] K_COLON    = 6'd49;
  localparam logic [KIND_W-1:0] K_DCOLON   = 6'd50;
  localparam logic [KIND_W-1:0] K_ERROR    = 6'd51;
  localparam logic [KIND_W-1:0] K_END      = 6'd52;

  localparam logic [ERR_W-1:0] E_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] E_BAD_CHAR = 3'd1;
  localparam logic [ERR_W-1:0] E_TILDE    = 3'd2;
  localparam logic [ERR_W-1:0] E_EXPONENT = 3'd3;
  localparam logic [ERR_W-1:0] E_ESCAPE   = 3'd4;
  localparam logic [ERR_W-1:0] E_UNTERM   = 3'd5;

  typedef struct packed {
    logic              sort;
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [LEN_W-1:0]  len;
    logic [7:0]        data;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]      count;
  } bundle_t;

endpackage

>>> rtl/script_token_lexer.sv
// The results of an accepted byte are registered in the bundle queue; the result ports show its head combinationally.
// Throughput: one source byte per cycle while the four-bundle result queue has room.
// The emitter gives one result per cycle while pop is held, so a byte with two or three results takes as many pops.
// Synchronous active-high reset: lexer idle at line 1 column 1, queue empty.
module script_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic        result_sort,
  output logic [5:0]  token_kind,
  output logic [2:0]  error_code,
  output logic [15:0] start_line,
  output logic [11:0] start_column,
  output logic [11:0] token_length,
  output logic [7:0]  decoded_byte,
  output logic        last_of_run
);

  stlex_pkg::bundle_t bundle;
  stlex_pkg::bundle_t head;
  logic               bundle_valid;
  logic               take;
  logic               deq;
  logic               q_empty;

  assign take = push && !full;

  stlex_core u_core (
    .clk, .rst, .take, .source_byte, .end_of_input, .bundle, .bundle_valid
  );

  stlex_queue u_queue (
    .clk, .rst, .wr(bundle_valid), .wdata(bundle), .rd(deq), .head, .full,
    .empty(q_empty)
  );

  stlex_emit u_emit (
    .clk, .rst, .head, .q_empty, .pop, .deq, .empty, .result_sort, .token_kind,
    .error_code, .start_line, .start_column, .token_length, .decoded_byte, .last_of_run
  );

endmodule

>>> rtl/stlex_core.sv
// Front end: lexer state machine, turns each accepted byte into a bundle of results.
module stlex_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             source_byte,
  input  logic                   end_of_input,
  output stlex_pkg::bundle_t     bundle,
  output logic                   bundle_valid
);

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_NUM_EXP, M_NUM_SIGN,
    M_NUM_EXPD, M_DOT1, M_DOT2, M_EQ, M_TILDE, M_LT, M_GT, M_COLON, M_MINUS,
    M_CMT_START, M_CMT_BRACKET, M_CMT_LINE, M_CMT_LONG, M_CMT_CLOSE, M_STR,
    M_STR_ESC, M_STR_DEC, M_STR_Z
  } mode_t;

  typedef struct packed {
    mode_t                        mode;
    logic [7:0][7:0]              wbuf;
    logic [stlex_pkg::LEN_W-1:0]  rlen;
    logic [stlex_pkg::LINE_W-1:0] tline;
    logic [stlex_pkg::COL_W-1:0]  tcol;
    logic [7:0]                   quote;
    logic [9:0]                   esc_val;
    logic [1:0]                   esc_dig;
  } lex_state_t;

  typedef struct packed {
    lex_state_t         st;
    logic               emit;
    stlex_pkg::result_t res;
    logic               cont;
  } pass_t;

  localparam int PASSES = 3;
  localparam logic [stlex_pkg::LEN_W-1:0]  LEN_TOP  = '1;
  localparam logic [stlex_pkg::LINE_W-1:0] LINE_TOP = '1;
  localparam logic [stlex_pkg::COL_W-1:0]  COL_TOP  = '1;
  localparam logic [stlex_pkg::LEN_W-1:0]  LEN_ONE  = stlex_pkg::LEN_W'(1);
  localparam logic [stlex_pkg::LINE_W-1:0] LINE_ONE = stlex_pkg::LINE_W'(1);
  localparam logic [stlex_pkg::COL_W-1:0]  COL_ONE  = stlex_pkg::COL_W'(1);
  localparam lex_state_t ST_RESET = '{mode: M_IDLE, wbuf: '0, rlen: '0, tline: LINE_ONE,
                                      tcol: COL_ONE, quote: '0, esc_val: '0,
                                      esc_dig: '0};

  lex_state_t                   st;
  lex_state_t                   st_next;
  logic [stlex_pkg::LINE_W-1:0] line;
  logic [stlex_pkg::COL_W-1:0]  col;
  pass_t                        p [PASSES+1];
  stlex_pkg::bundle_t           b;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word_start(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic [stlex_pkg::LEN_W-1:0] bump(logic [stlex_pkg::LEN_W-1:0] l);
    return (l == LEN_TOP) ? l : l + 1'b1;
  endfunction

  function automatic stlex_pkg::result_t tok(lex_state_t s, logic [5:0] k, logic [2:0] e);
    stlex_pkg::result_t r;
    r.sort = stlex_pkg::SORT_TOKEN;
    r.kind = k;
    r.err  = e;
    r.line = s.tline;
    r.col  = s.tcol;
    r.len  = s.rlen;
    r.data = 8'd0;
    return r;
  endfunction

  function automatic stlex_pkg::result_t byte_res(lex_state_t s, logic [7:0] d);
    stlex_pkg::result_t r;
    r.sort = stlex_pkg::SORT_BYTE;
    r.kind = stlex_pkg::K_STRING;
    r.err  = stlex_pkg::E_NONE;
    r.line = s.tline;
    r.col  = s.tcol;
    r.len  = '0;
    r.data = d;
    return r;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    case (c)
      8'h28:   return stlex_pkg::K_LPAREN;
      8'h29:   return stlex_pkg::K_RPAREN;
      8'h7b:   return stlex_pkg::K_LBRACE;
      8'h7d:   return stlex_pkg::K_RBRACE;
      8'h5b:   return stlex_pkg::K_LBRACKET;
      8'h5d:   return stlex_pkg::K_RBRACKET;
      8'h2c:   return stlex_pkg::K_COMMA;
      8'h3b:   return stlex_pkg::K_SEMI;
      8'h25:   return stlex_pkg::K_PERCENT;
      8'h5e:   return stlex_pkg::K_CARET;
      8'h23:   return stlex_pkg::K_HASH;
      8'h2b:   return stlex_pkg::K_PLUS;
      8'h2a:   return stlex_pkg::K_STAR;
      8'h2f:   return stlex_pkg::K_SLASH;
      default: return stlex_pkg::K_IDENT;
    endcase
  endfunction

  // Keyword text is right-justified in 64 bits, first character highest.
  function automatic logic [5:0] keyword_kind(logic [7:0][7:0] w,
                                              logic [stlex_pkg::LEN_W-1:0] l);
    logic [63:0] txt [21];
    logic [3:0]  kl [21];
    logic [5:0]  k;
    logic        hit;
    txt = '{"and", "break", "do", "else", "elseif", "end", "false", "for",
            "function", "if", "in", "local", "nil", "not", "or", "repeat",
            "return", "then", "true", "until", "while"};
    kl  = '{4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd8, 4'd2, 4'd2,
            4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5};
    k = stlex_pkg::K_IDENT;
    for (int i = 0; i < 21; i++) begin
      hit = (l == stlex_pkg::LEN_W'(kl[i]));
      for (int j = 0; j < 8; j++) begin
        if (j < int'(kl[i]) && w[j] != txt[i][8*(int'(kl[i])-1-j) +: 8]) hit = 1'b0;
      end
      if (hit) k = 6'(i + 1);
    end
    return k;
  endfunction

  function automatic pass_t pair_op(pass_t q, logic [7:0] c, logic eof, logic [7:0] want,
                                    logic [5:0] k2, logic [5:0] k1, logic [2:0] e);
    pass_t r;
    r = q;
    r.emit = 1'b1;
    r.st.mode = M_IDLE;
    if (!eof && c == want) begin
      r.st.rlen = bump(q.st.rlen);
      r.res = tok(r.st, k2, stlex_pkg::E_NONE);
    end else begin
      r.res = tok(q.st, k1, e);
      r.cont = 1'b1;
    end
    return r;
  endfunction

  function automatic pass_t lex_pass(lex_state_t s, logic [7:0] c, logic eof,
                                     logic [stlex_pkg::LINE_W-1:0] ln,
                                     logic [stlex_pkg::COL_W-1:0] cl);
    pass_t      r;
    logic [5:0] k;
    logic [9:0] v;
    r.st = s;
    r.emit = 1'b0;
    r.res = '0;
    r.cont = 1'b0;
    k = single_kind(c);
    v = 10'(({s.esc_val, 3'b000}) + ({s.esc_val, 1'b0}) + {9'd0, c[3:0]});
    case (s.mode)
      M_IDLE: begin
        if (eof) begin
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_END, stlex_pkg::E_NONE);
          r.res.line = ln;
          r.res.col = cl;
          r.res.len = '0;
        end else if (!(c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a)) begin
          r.st.tline = ln;
          r.st.tcol = cl;
          r.st.rlen = LEN_ONE;
          if (is_word_start(c)) begin
            r.st.wbuf[0] = c;
            r.st.mode = M_IDENT;
          end else if (is_digit(c)) begin
            r.st.mode = M_NUM_INT;
          end else if (k != stlex_pkg::K_IDENT) begin
            r.emit = 1'b1;
            r.res = tok(r.st, k, stlex_pkg::E_NONE);
          end else begin
            case (c)
              8'h2d: r.st.mode = M_MINUS;
              8'h2e: r.st.mode = M_DOT1;
              8'h3d: r.st.mode = M_EQ;
              8'h7e: r.st.mode = M_TILDE;
              8'h3c: r.st.mode = M_LT;
              8'h3e: r.st.mode = M_GT;
              8'h3a: r.st.mode = M_COLON;
              8'h22, 8'h27: begin
                r.st.quote = c;
                r.st.mode = M_STR;
              end
              default: begin
                r.emit = 1'b1;
                r.res = tok(r.st, stlex_pkg::K_ERROR, stlex_pkg::E_BAD_CHAR);
              end
            endcase
          end
        end
      end
      M_IDENT: begin
        if (!eof && (is_word_start(c) || is_digit(c))) begin
          if (s.rlen < 8) r.st.wbuf[s.rlen[2:0]] = c;
          r.st.rlen = bump(s.rlen);
        end else begin
          r.emit = 1'b1;
          r.res = tok(s, keyword_kind(s.wbuf, s.rlen), stlex_pkg::E_NONE);
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end
      end
      M_NUM_INT, M_NUM_FRAC: begin
        if (!eof && is_digit(c)) begin
          r.st.rlen = bump(s.rlen);
        end else if (!eof && (c == 8'h65 || c == 8'h45)) begin
          r.st.rlen = bump(s.rlen);
          r.st.mode = M_NUM_EXP;
        end else if (!eof && c == 8'h2e && s.mode == M_NUM_INT) begin
          r.st.rlen = bump(s.rlen);
          r.st.mode = M_NUM_DOT;
        end else begin
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_NUMBER, stlex_pkg::E_NONE);
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end
      end
      M_NUM_DOT: begin
        if (!eof && is_digit(c)) begin
          r.st.rlen = bump(s.rlen);
          r.st.mode = M_NUM_FRAC;
        end else begin
          // The dot is handed back: the number loses it and a token opening with the dot starts there.
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_NUMBER, stlex_pkg::E_NONE);
          r.res.len = (s.rlen == LEN_TOP) ? LEN_TOP :
                      ((s.rlen != 0) ? s.rlen - 1'b1 : '0);
          r.st.tline = ln;
          r.st.tcol = (cl == COL_TOP) ? COL_TOP : ((cl > COL_ONE) ? cl - 1'b1 : COL_ONE);
          r.st.rlen = LEN_ONE;
          r.st.mode = M_DOT1;
          r.cont = 1'b1;
        end
      end
      M_NUM_EXP, M_NUM_SIGN: begin
        if (!eof && (c == 8'h2b || c == 8'h2d) && s.mode == M_NUM_EXP) begin
          r.st.rlen = bump(s.rlen);
          r.st.mode = M_NUM_SIGN;
        end else if (!eof && is_digit(c)) begin
          r.st.rlen = bump(s.rlen);
          r.st.mode = M_NUM_EXPD;
        end else begin
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_ERROR, stlex_pkg::E_EXPONENT);
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end
      end
      M_NUM_EXPD: begin
        if (!eof && is_digit(c)) begin
          r.st.rlen = bump(s.rlen);
        end else begin
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_NUMBER, stlex_pkg::E_NONE);
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end
      end
      M_DOT1: begin
        if (!eof && c == 8'h2e) begin
          r.st.rlen = bump(s.rlen);
          r.st.mode = M_DOT2;
        end else if (!eof && is_digit(c)) begin
          r.st.rlen = bump(s.rlen);
          r.st.mode = M_NUM_FRAC;
        end else begin
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_DOT, stlex_pkg::E_NONE);
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end
      end
      M_DOT2:  r = pair_op(r, c, eof, 8'h2e, stlex_pkg::K_ELLIPSIS, stlex_pkg::K_CONCAT,
                           stlex_pkg::E_NONE);
      M_EQ:    r = pair_op(r, c, eof, 8'h3d, stlex_pkg::K_EQ, stlex_pkg::K_ASSIGN,
                           stlex_pkg::E_NONE);
      M_TILDE: r = pair_op(r, c, eof, 8'h3d, stlex_pkg::K_NE, stlex_pkg::K_ERROR,
                           stlex_pkg::E_TILDE);
      M_LT:    r = pair_op(r, c, eof, 8'h3d, stlex_pkg::K_LE, stlex_pkg::K_LT,
                           stlex_pkg::E_NONE);
      M_GT:    r = pair_op(r, c, eof, 8'h3d, stlex_pkg::K_GE, stlex_pkg::K_GT,
                           stlex_pkg::E_NONE);
      M_COLON: r = pair_op(r, c, eof, 8'h3a, stlex_pkg::K_DCOLON, stlex_pkg::K_COLON,
                           stlex_pkg::E_NONE);
      M_MINUS: begin
        if (!eof && c == 8'h2d) begin
          r.st.mode = M_CMT_START;
        end else begin
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_MINUS, stlex_pkg::E_NONE);
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end
      end
      M_CMT_START, M_CMT_BRACKET: begin
        if (eof || c == 8'h0a) begin
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end else if (c == 8'h5b) begin
          r.st.mode = (s.mode == M_CMT_START) ? M_CMT_BRACKET : M_CMT_LONG;
        end else begin
          r.st.mode = M_CMT_LINE;
        end
      end
      M_CMT_LINE: begin
        if (eof || c == 8'h0a) begin
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end
      end
      M_CMT_LONG: begin
        if (eof) begin
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end else if (c == 8'h5d) begin
          r.st.mode = M_CMT_CLOSE;
        end
      end
      M_CMT_CLOSE: begin
        if (eof) begin
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end else begin
          r.st.mode = (c == 8'h5d) ? M_IDLE : M_CMT_LONG;
        end
      end
      M_STR: begin
        if (eof || c == 8'h0a) begin
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_ERROR, stlex_pkg::E_UNTERM);
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end else begin
          r.st.rlen = bump(s.rlen);
          if (c == s.quote) begin
            r.emit = 1'b1;
            r.res = tok(r.st, stlex_pkg::K_STRING, stlex_pkg::E_NONE);
            r.st.mode = M_IDLE;
          end else if (c == 8'h5c) begin
            r.st.mode = M_STR_ESC;
          end else begin
            r.emit = 1'b1;
            r.res = byte_res(s, c);
          end
        end
      end
      M_STR_ESC: begin
        if (eof) begin
          r.emit = 1'b1;
          r.res = tok(s, stlex_pkg::K_ERROR, stlex_pkg::E_UNTERM);
          r.st.mode = M_IDLE;
          r.cont = 1'b1;
        end else begin
          r.st.rlen = bump(s.rlen);
          r.st.mode = M_STR;
          r.emit = 1'b1;
          case (c)
            8'h61:   r.res = byte_res(s, 8'd7);
            8'h62:   r.res = byte_res(s, 8'd8);
            8'h66:   r.res = byte_res(s, 8'd12);
            8'h6e:   r.res = byte_res(s, 8'd10);
            8'h72:   r.res = byte_res(s, 8'd13);
            8'h74:   r.res = byte_res(s, 8'd9);
            8'h76:   r.res = byte_res(s, 8'd11);
            8'h7a: begin
              r.emit = 1'b0;
              r.st.mode = M_STR_Z;
            end
            default: begin
              if (is_digit(c)) begin
                r.emit = 1'b0;
                r.st.esc_val = {6'd0, c[3:0]};
                r.st.esc_dig = 2'd1;
                r.st.mode = M_STR_DEC;
              end else begin
                r.res = byte_res(s, c);
              end
            end
          endcase
        end
      end
      M_STR_DEC: begin
        if (!eof && is_digit(c) && s.esc_dig < 2'd3) begin
          r.st.rlen = bump(s.rlen);
          r.st.esc_val = v;
          r.st.esc_dig = s.esc_dig + 1'b1;
          if (s.esc_dig == 2'd2) begin
            r.emit = 1'b1;
            if (v > 10'd255) begin
              r.res = tok(r.st, stlex_pkg::K_ERROR, stlex_pkg::E_ESCAPE);
              r.st.mode = M_IDLE;
            end else begin
              r.res = byte_res(s, v[7:0]);
              r.st.mode = M_STR;
            end
          end
        end else begin
          r.emit = 1'b1;
          r.res = byte_res(s, s.esc_val[7:0]);
          r.st.mode = M_STR;
          r.cont = 1'b1;
        end
      end
      M_STR_Z: begin
        if (!eof && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d))) begin
          r.st.rlen = bump(s.rlen);
        end else begin
          r.st.mode = M_STR;
          r.cont = 1'b1;
        end
      end
      default: begin
        r.st.mode = M_IDLE;
        r.cont = 1'b1;
      end
    endcase
    return r;
  endfunction

  // A byte may close up to two tokens and hand itself on each time, so up to three passes run per beat.
  always_comb begin
    p[0] = '0;
    p[0].st = st;
    p[0].cont = 1'b1;
    b = '0;
    for (int i = 0; i < PASSES; i++) begin
      if (p[i].cont) begin
        p[i+1] = lex_pass(p[i].st, source_byte, end_of_input, line, col);
      end else begin
        p[i+1] = p[i];
        p[i+1].emit = 1'b0;
      end
      if (p[i+1].emit) begin
        b.res[b.count] = p[i+1].res;
        b.count = b.count + 1'b1;
      end
    end
    st_next = p[PASSES].st;
  end

  assign bundle = b;
  assign bundle_valid = take && (b.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
      line <= LINE_ONE;
      col <= COL_ONE;
    end else if (take) begin
      st <= st_next;
      if (!end_of_input) begin
        if (source_byte == 8'h0a) begin
          if (line != LINE_TOP) line <= line + 1'b1;
          col <= COL_ONE;
        end else if (col != COL_TOP) begin
          col <= col + 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_eof_gives_end: assert property (@(posedge clk) disable iff (rst)
    take && end_of_input |-> bundle_valid &&
      b.res[b.count - 1'b1].kind == stlex_pkg::K_END)
    else $error("end of input did not close with an end token");
  a_eof_to_idle: assert property (@(posedge clk) disable iff (rst)
    take && end_of_input |=> st.mode == M_IDLE)
    else $error("lexer not idle after end of input");
  a_line_steps: assert property (@(posedge clk) disable iff (rst)
    take && !end_of_input && source_byte == 8'h0a |=> col == COL_ONE)
    else $error("column not reset after newline");
`endif

endmodule

>>> rtl/stlex_queue.sv
// Bundle queue between the lexer front end and the result emitter.
module stlex_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  stlex_pkg::bundle_t wdata,
  input  logic               rd,
  output stlex_pkg::bundle_t head,
  output logic               full,
  output logic               empty
);

  stlex_pkg::bundle_t                mem [stlex_pkg::Q_DEPTH];
  logic [stlex_pkg::Q_PTR_W-1:0]     wptr;
  logic [stlex_pkg::Q_PTR_W-1:0]     rptr;
  logic [stlex_pkg::Q_PTR_W:0]       fill;

  assign full  = (fill == (stlex_pkg::Q_PTR_W + 1)'(stlex_pkg::Q_DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      if (wr && !rd) fill <= fill + 1'b1;
      else if (rd && !wr) fill <= fill - 1'b1;
    end
  end

endmodule

>>> rtl/stlex_emit.sv
// Back end: hands out the results of the oldest bundle one at a time, advancing on each pop.
module stlex_emit (
  input  logic               clk,
  input  logic               rst,
  input  stlex_pkg::bundle_t head,
  input  logic               q_empty,
  input  logic               pop,
  output logic               deq,
  output logic               empty,
  output logic               result_sort,
  output logic [5:0]         token_kind,
  output logic [2:0]         error_code,
  output logic [15:0]        start_line,
  output logic [11:0]        start_column,
  output logic [11:0]        token_length,
  output logic [7:0]         decoded_byte,
  output logic               last_of_run
);

  logic [stlex_pkg::CNT_W-1:0] idx;
  stlex_pkg::result_t          cur;

  assign cur          = head.res[idx];
  assign empty        = q_empty;
  assign last_of_run  = (idx + 1'b1) == head.count;
  assign deq          = pop && !q_empty && last_of_run;
  assign result_sort  = cur.sort;
  assign token_kind   = cur.kind;
  assign error_code   = cur.err;
  assign start_line   = cur.line;
  assign start_column = cur.col;
  assign token_length = cur.len;
  assign decoded_byte = cur.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && !q_empty) begin
      idx <= last_of_run ? '0 : idx + 1'b1;
    end
  end

endmodule
